>>> rtl/core/crcbp_pkg.sv
`timescale 1ns / 1ps

package crcbp_pkg;

  localparam logic [31:0] CRC_POLY = 32'hEDB88320;
  localparam logic [31:0] CRC_INIT = 32'hFFFFFFFF;

  localparam logic [7:0]  SIG_FIRST_RST  = 8'd96;
  localparam logic [7:0]  SIG_SECOND_RST = 8'd234;
  localparam logic [15:0] MAX_LEN_RST    = 16'd2600;

  // configuration register indexes
  localparam logic [1:0] CFG_SIG_FIRST  = 2'd0;
  localparam logic [1:0] CFG_SIG_SECOND = 2'd1;
  localparam logic [1:0] CFG_MAX_LEN    = 2'd2;

  typedef enum logic [2:0] {
    EV_DATA   = 3'd0,
    EV_OK     = 3'd1,
    EV_END    = 3'd2,
    EV_BADSIG = 3'd3,
    EV_BADCRC = 3'd4,
    EV_TRUNC  = 3'd5,
    EV_BADLEN = 3'd6
  } ev_t;

  typedef enum logic [11:0] {
    PH_SIG1     = 12'b0000_0000_0001,
    PH_SIG2_OK  = 12'b0000_0000_0010,
    PH_SIG2_BAD = 12'b0000_0000_0100,
    PH_HUNT1    = 12'b0000_0000_1000,
    PH_HUNT2    = 12'b0000_0001_0000,
    PH_LEN_LO   = 12'b0000_0010_0000,
    PH_LEN_HI   = 12'b0000_0100_0000,
    PH_DATA     = 12'b0000_1000_0000,
    PH_CRC0     = 12'b0001_0000_0000,
    PH_CRC1     = 12'b0010_0000_0000,
    PH_CRC2     = 12'b0100_0000_0000,
    PH_CRC3     = 12'b1000_0000_0000
  } phase_t;

  typedef struct packed {
    logic [7:0]  sig_first;
    logic [7:0]  sig_second;
    logic [15:0] max_len;
  } cfg_t;

  typedef struct packed {
    logic        valid;
    ev_t         ev;
    logic [7:0]  data;
    logic [15:0] len;
    logic        is_main;
  } res_t;

endpackage

>>> rtl/core/crcbp_crc.sv
`timescale 1ns / 1ps

// Reflected CRC-32, one byte per call, bit steps unrolled.
module crcbp_crc import crcbp_pkg::*; (
  input  logic [31:0] crc_in,
  input  logic [7:0]  data_in,
  output logic [31:0] crc_out
);

  always_comb begin
    logic [31:0] c;
    c = crc_in ^ {24'd0, data_in};
    for (int i = 0; i < 8; i++) begin
      c = c[0] ? ((c >> 1) ^ CRC_POLY) : (c >> 1);
    end
    crc_out = c;
  end

endmodule

>>> rtl/core/crcbp_fsm.sv
`timescale 1ns / 1ps

module crcbp_fsm import crcbp_pkg::*; (
  input  logic       clk,
  input  logic       rst_n,
  input  logic       accept,
  input  logic [7:0] byte_in,
  input  logic       done_in,
  input  cfg_t       cfg,
  output res_t       res
);

  phase_t      phase_r,  phase_nxt;
  logic [15:0] len_r,    len_nxt;
  logic [15:0] cnt_r,    cnt_nxt;
  logic [31:0] crc_r,    crc_nxt;
  logic [23:0] rcv_r,    rcv_nxt;   // top CRC byte is compared as it arrives
  logic        main_r,   main_nxt;

  logic [31:0] crc_upd;
  logic [15:0] len_full;
  logic [15:0] cnt_inc;

  crcbp_crc u_crc (
    .crc_in  (crc_r),
    .data_in (byte_in),
    .crc_out (crc_upd)
  );

  assign len_full = {byte_in, len_r[7:0]};
  assign cnt_inc  = cnt_r + 16'd1;

  always_comb begin
    phase_nxt   = phase_r;
    len_nxt     = len_r;
    cnt_nxt     = cnt_r;
    crc_nxt     = crc_r;
    rcv_nxt     = rcv_r;
    main_nxt    = main_r;
    res.valid   = 1'b0;
    res.ev      = EV_DATA;
    res.data    = 8'd0;
    res.len     = len_r;
    res.is_main = main_r;

    if (done_in) begin
      if (phase_r != PH_SIG1 && phase_r != PH_HUNT1 && phase_r != PH_HUNT2) begin
        res.valid = 1'b1;
        res.ev    = EV_TRUNC;
      end
      phase_nxt = PH_SIG1;
      len_nxt   = 16'd0;
      cnt_nxt   = 16'd0;
      crc_nxt   = CRC_INIT;
      rcv_nxt   = 24'd0;
      main_nxt  = 1'b1;
    end else begin
      case (phase_r)
        PH_SIG1: begin
          phase_nxt = (byte_in == cfg.sig_first) ? PH_SIG2_OK : PH_SIG2_BAD;
        end
        PH_SIG2_OK, PH_SIG2_BAD: begin
          if (phase_r == PH_SIG2_OK && byte_in == cfg.sig_second) begin
            phase_nxt = PH_LEN_LO;
          end else begin
            res.valid = 1'b1;
            res.ev    = EV_BADSIG;
            phase_nxt = PH_HUNT1;
            len_nxt   = 16'd0;
            cnt_nxt   = 16'd0;
            crc_nxt   = CRC_INIT;
            rcv_nxt   = 24'd0;
            main_nxt  = 1'b1;
          end
        end
        PH_HUNT1: begin
          if (byte_in == cfg.sig_first) phase_nxt = PH_HUNT2;
        end
        PH_HUNT2: begin
          if (byte_in == cfg.sig_second) begin
            phase_nxt = PH_LEN_LO;
          end else if (byte_in != cfg.sig_first) begin
            phase_nxt = PH_HUNT1;
          end
        end
        PH_LEN_LO: begin
          len_nxt   = {8'd0, byte_in};
          phase_nxt = PH_LEN_HI;
        end
        PH_LEN_HI: begin
          res.len = len_full;
          if (len_full == 16'd0 || len_full > cfg.max_len) begin
            res.valid = 1'b1;
            // zero length closes a group only after the main block
            if (len_full == 16'd0 && !main_r) begin
              res.ev    = EV_END;
              phase_nxt = PH_SIG1;
            end else begin
              res.ev    = EV_BADLEN;
              phase_nxt = PH_HUNT1;
            end
            len_nxt  = 16'd0;
            cnt_nxt  = 16'd0;
            crc_nxt  = CRC_INIT;
            rcv_nxt  = 24'd0;
            main_nxt = 1'b1;
          end else begin
            len_nxt   = len_full;
            cnt_nxt   = 16'd0;
            crc_nxt   = CRC_INIT;
            phase_nxt = PH_DATA;
          end
        end
        PH_DATA: begin
          crc_nxt   = crc_upd;
          cnt_nxt   = cnt_inc;
          res.valid = 1'b1;
          res.ev    = EV_DATA;
          res.data  = byte_in;
          if (cnt_inc >= len_r) phase_nxt = PH_CRC0;
        end
        PH_CRC0: begin
          rcv_nxt   = {16'd0, byte_in};
          phase_nxt = PH_CRC1;
        end
        PH_CRC1: begin
          rcv_nxt   = {8'd0, byte_in, rcv_r[7:0]};
          phase_nxt = PH_CRC2;
        end
        PH_CRC2: begin
          rcv_nxt   = {byte_in, rcv_r[15:0]};
          phase_nxt = PH_CRC3;
        end
        PH_CRC3: begin
          res.valid = 1'b1;
          len_nxt   = 16'd0;
          cnt_nxt   = 16'd0;
          crc_nxt   = CRC_INIT;
          rcv_nxt   = 24'd0;
          if (~crc_r == {byte_in, rcv_r}) begin
            res.ev    = EV_OK;
            main_nxt  = 1'b0;
            phase_nxt = PH_LEN_LO;
          end else begin
            res.ev    = EV_BADCRC;
            main_nxt  = 1'b1;
            phase_nxt = PH_HUNT1;
          end
        end
        default: begin
          phase_nxt = PH_HUNT1;
          len_nxt   = 16'd0;
          cnt_nxt   = 16'd0;
          crc_nxt   = CRC_INIT;
          rcv_nxt   = 24'd0;
          main_nxt  = 1'b1;
        end
      endcase
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      phase_r <= PH_SIG1;
      len_r   <= 16'd0;
      cnt_r   <= 16'd0;
      crc_r   <= CRC_INIT;
      rcv_r   <= 24'd0;
      main_r  <= 1'b1;
    end else if (accept) begin
      phase_r <= phase_nxt;
      len_r   <= len_nxt;
      cnt_r   <= cnt_nxt;
      crc_r   <= crc_nxt;
      rcv_r   <= rcv_nxt;
      main_r  <= main_nxt;
    end
  end

endmodule

>>> rtl/core/crcbp_outreg.sv
`timescale 1ns / 1ps

// Result register; refills in the same cycle the held result is taken.
module crcbp_outreg import crcbp_pkg::*; (
  input  logic clk,
  input  logic rst_n,
  input  res_t res_in,
  output logic in_ready,
  input  logic in_accept,
  input  logic out_ready,
  output res_t res_out
);

  logic valid_r, valid_nxt;
  res_t pay_r;

  assign in_ready = !valid_r || out_ready;

  always_comb begin
    valid_nxt = valid_r;
    if (in_accept) begin
      valid_nxt = res_in.valid;
    end else if (out_ready) begin
      valid_nxt = 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      valid_r <= 1'b0;
    end else begin
      valid_r <= valid_nxt;
    end
  end

  always_ff @(posedge clk) begin
    if (in_accept && res_in.valid) begin
      pay_r <= res_in;
    end
  end

  always_comb begin
    res_out       = pay_r;
    res_out.valid = valid_r;
  end

endmodule

>>> rtl/core/crc_checked_header_block_parser.sv
// Latency: a result appears on out_* the cycle after its byte transaction.
// Throughput: one byte per cycle while out_ready is high; the CRC-32 byte update is
//   a combinational unrolled step and the result register refills as it is drained.
// Reset: rst_n synchronous, active low; parser waits for first signature
//   byte, config registers return to their defaults, result register empties.
`timescale 1ns / 1ps

module crc_checked_header_block_parser import crcbp_pkg::*; (
  input  logic        clk,
  input  logic        rst_n,
  // byte stream in
  input  logic        in_valid,
  output logic        in_ready,
  input  logic [7:0]  in_byte_value,
  input  logic        in_stream_done,
  // events out
  output logic        out_valid,
  input  logic        out_ready,
  output logic [2:0]  out_event_res,
  output logic [7:0]  out_data_byte,
  output logic [15:0] out_block_length,
  output logic        out_is_main_block,
  // configuration writes
  input  logic        cfg_we,
  input  logic [1:0]  cfg_index,
  input  logic [15:0] cfg_wdata
);

  cfg_t cfg_r;
  res_t res_comb;
  res_t res_q;
  logic accept;

  // A transaction is taken whenever the result register is free or being
  // emptied this cycle, so bytes flow every cycle with out_ready high.
  assign accept = in_valid && in_ready;

  // Configuration registers; an unknown index is dropped.
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      cfg_r.sig_first  <= SIG_FIRST_RST;
      cfg_r.sig_second <= SIG_SECOND_RST;
      cfg_r.max_len    <= MAX_LEN_RST;
    end else if (cfg_we) begin
      case (cfg_index)
        CFG_SIG_FIRST:  cfg_r.sig_first  <= cfg_wdata[7:0];
        CFG_SIG_SECOND: cfg_r.sig_second <= cfg_wdata[7:0];
        CFG_MAX_LEN:    cfg_r.max_len    <= cfg_wdata;
        default: ;
      endcase
    end
  end

  // Parser state and per-byte decision logic.
  crcbp_fsm u_fsm (
    .clk     (clk),
    .rst_n   (rst_n),
    .accept  (accept),
    .byte_in (in_byte_value),
    .done_in (in_stream_done),
    .cfg     (cfg_r),
    .res     (res_comb)
  );

  // Result register between the parser and the output channel.
  crcbp_outreg u_out (
    .clk       (clk),
    .rst_n     (rst_n),
    .res_in    (res_comb),
    .in_ready  (in_ready),
    .in_accept (accept),
    .out_ready (out_ready),
    .res_out   (res_q)
  );

  assign out_valid         = res_q.valid;
  assign out_event_res     = res_q.ev;
  assign out_data_byte     = res_q.data;
  assign out_block_length  = res_q.len;
  assign out_is_main_block = res_q.is_main;

  // Stalling on input only happens while a result is held.
  a_ready_stall: assert property (@(posedge clk) disable iff (!rst_n)
    !in_ready |-> out_valid)
    else $error("in_ready low with no result held");

  // End of stream can only produce a truncation transaction.
  a_done_trunc: assert property (@(posedge clk) disable iff (!rst_n)
    (in_valid && in_ready && in_stream_done) |=>
      (!out_valid || out_event_res == EV_TRUNC))
    else $error("stream end produced a non-truncation event");

  // Data bytes only come from a block with nonzero length.
  a_data_len: assert property (@(posedge clk) disable iff (!rst_n)
    (out_valid && out_event_res == EV_DATA) |-> (out_block_length != 16'd0))
    else $error("data byte with zero block length");

  // Non-data events carry a zero data byte.
  a_data_zero: assert property (@(posedge clk) disable iff (!rst_n)
    (out_valid && out_event_res != EV_DATA) |-> (out_data_byte == 8'd0))
    else $error("nonzero data byte on a status event");

endmodule

>>> verif/crc_checked_header_block_parser_test.sv
`timescale 1ns / 1ps

// Stream-parser bench: bytes go in one transaction at a time and a scoreboard
// predicts each event as the byte is accepted. Every returned event is checked
// field by field against the oldest prediction.
module crc_checked_header_block_parser_test;
  import crcbp_pkg::*;

  // Cycles with no transaction on either channel before the run is abandoned.
  localparam int WATCHDOG_LIMIT = 1000;
  // Size of the bulk random phase, in stream transactions.
  localparam int RANDOM_ITEMS   = 60;

  // One predicted event, in the order the DUT must return them.
  typedef struct {
    ev_t         ev;
    logic [7:0]  data;
    logic [15:0] len;
    logic        main_blk;
  } parser_event_t;

  // One planned input transaction: a byte, or the end-of-stream marker.
  typedef struct packed {
    logic       done;
    logic [7:0] value;
  } stream_item_t;

  logic        clk            = 1'b0;
  logic        rst_n          = 1'b0;
  logic        in_valid       = 1'b0;
  logic        in_ready;
  logic [7:0]  in_byte_value  = 8'h00;
  logic        in_stream_done = 1'b0;
  logic        out_valid;
  logic        out_ready      = 1'b0;
  logic [2:0]  out_event_res;
  logic [7:0]  out_data_byte;
  logic [15:0] out_block_length;
  logic        out_is_main_block;
  logic        cfg_we         = 1'b0;
  logic [1:0]  cfg_index      = CFG_SIG_FIRST;
  logic [15:0] cfg_wdata      = 16'h0000;

  // Scoreboard copy of the parser state and its registers.
  phase_t      ph_q         = PH_SIG1;
  logic [15:0] len_q        = 16'h0000;
  logic [15:0] cnt_q        = 16'h0000;
  logic [31:0] crc_q        = CRC_INIT;
  logic [31:0] crc_rx_q     = 32'h0000_0000;
  logic        main_q       = 1'b1;
  logic [7:0]  sig_first_q  = SIG_FIRST_RST;
  logic [7:0]  sig_second_q = SIG_SECOND_RST;
  logic [15:0] max_len_q    = MAX_LEN_RST;

  parser_event_t pending_events[$];
  stream_item_t  stream_plan[$];

  int error_count     = 0;
  int items_sent      = 0;
  int results_checked = 0;
  int ev_tally[0:6];
  int gap_pct         = 0;
  int stall_pct       = 0;
  int stall_left      = 0;
  int quiet_cycles    = 0;
  bit idling_on       = 1'b1;

  crc_checked_header_block_parser dut (
    .clk               (clk),
    .rst_n             (rst_n),
    .in_valid          (in_valid),
    .in_ready          (in_ready),
    .in_byte_value     (in_byte_value),
    .in_stream_done    (in_stream_done),
    .out_valid         (out_valid),
    .out_ready         (out_ready),
    .out_event_res     (out_event_res),
    .out_data_byte     (out_data_byte),
    .out_block_length  (out_block_length),
    .out_is_main_block (out_is_main_block),
    .cfg_we            (cfg_we),
    .cfg_index         (cfg_index),
    .cfg_wdata         (cfg_wdata)
  );

  always begin
    #5 clk = 1'b1;
    #5 clk = 1'b0;
  end

  // ---------------------------------------------------------------------------
  // Scoreboard: CRC-32 (reflected, LSB first) and the parser state machine
  // ---------------------------------------------------------------------------

  function automatic logic [31:0] crc_step(input logic [31:0] c, input logic [7:0] b);
    logic [31:0] r;
    int          i;
    r = c ^ {24'h000000, b};
    for (i = 0; i < 8; i++) r = r[0] ? ((r >> 1) ^ CRC_POLY) : (r >> 1);
    return r;
  endfunction

  // Event fields carry the length and block kind as they stand when it fires.
  function automatic void post_event(input ev_t ev, input logic [7:0] d);
    parser_event_t e;
    e.ev       = ev;
    e.data     = d;
    e.len      = len_q;
    e.main_blk = main_q;
    pending_events.push_back(e);
  endfunction

  function automatic void restart_group(input phase_t nxt);
    ph_q     = nxt;
    len_q    = 16'h0000;
    cnt_q    = 16'h0000;
    crc_q    = CRC_INIT;
    crc_rx_q = 32'h0000_0000;
    main_q   = 1'b1;
  endfunction

  function automatic void predict_parser_events(input logic [7:0] b, input logic done);
    if (done) begin
      // silent at a group boundary or while hunting, truncation anywhere else
      if (ph_q != PH_SIG1 && ph_q != PH_HUNT1 && ph_q != PH_HUNT2)
        post_event(EV_TRUNC, 8'h00);
      restart_group(PH_SIG1);
      return;
    end
    case (ph_q)
      PH_SIG1: begin
        ph_q = (b == sig_first_q) ? PH_SIG2_OK : PH_SIG2_BAD;
      end
      PH_SIG2_OK, PH_SIG2_BAD: begin
        // both signature bytes are consumed before a mismatch is flagged
        if (ph_q == PH_SIG2_OK && b == sig_second_q) begin
          ph_q = PH_LEN_LO;
        end else begin
          post_event(EV_BADSIG, 8'h00);
          restart_group(PH_HUNT1);
        end
      end
      PH_HUNT1: begin
        if (b == sig_first_q) ph_q = PH_HUNT2;
      end
      PH_HUNT2: begin
        if (b == sig_second_q) ph_q = PH_LEN_LO;
        else if (b != sig_first_q) ph_q = PH_HUNT1;
      end
      PH_LEN_LO: begin
        len_q = {8'h00, b};
        ph_q  = PH_LEN_HI;
      end
      PH_LEN_HI: begin
        len_q = {b, len_q[7:0]};
        if (len_q == 16'h0000) begin
          // zero length: bad on the main block, group end on an extended one
          if (main_q) begin
            post_event(EV_BADLEN, 8'h00);
            restart_group(PH_HUNT1);
          end else begin
            post_event(EV_END, 8'h00);
            restart_group(PH_SIG1);
          end
        end else if (len_q > max_len_q) begin
          post_event(EV_BADLEN, 8'h00);
          restart_group(PH_HUNT1);
        end else begin
          cnt_q = 16'h0000;
          crc_q = CRC_INIT;
          ph_q  = PH_DATA;
        end
      end
      PH_DATA: begin
        crc_q = crc_step(crc_q, b);
        cnt_q = cnt_q + 16'd1;
        post_event(EV_DATA, b);
        if (cnt_q >= len_q) ph_q = PH_CRC0;
      end
      PH_CRC0: begin
        crc_rx_q = {24'h000000, b};
        ph_q     = PH_CRC1;
      end
      PH_CRC1: begin
        crc_rx_q[15:8] = b;
        ph_q           = PH_CRC2;
      end
      PH_CRC2: begin
        crc_rx_q[23:16] = b;
        ph_q            = PH_CRC3;
      end
      PH_CRC3: begin
        crc_rx_q[31:24] = b;
        if (~crc_q == crc_rx_q) begin
          post_event(EV_OK, 8'h00);
          main_q   = 1'b0;
          len_q    = 16'h0000;
          cnt_q    = 16'h0000;
          crc_q    = CRC_INIT;
          crc_rx_q = 32'h0000_0000;
          ph_q     = PH_LEN_LO;
        end else begin
          post_event(EV_BADCRC, 8'h00);
          restart_group(PH_HUNT1);
        end
      end
      default: begin
        restart_group(PH_HUNT1);
      end
    endcase
  endfunction

  // ---------------------------------------------------------------------------
  // Checking
  // ---------------------------------------------------------------------------

  task automatic report_mismatch(input string what);
    error_count++;
    if (error_count <= 50) $display("MISMATCH at %0t: %s", $time, what);
  endtask

  task automatic check_event();
    parser_event_t want;
    if (pending_events.size() == 0) begin
      report_mismatch($sformatf("unexpected event %0d (data %02h len %0d main %0b)",
                                out_event_res, out_data_byte, out_block_length,
                                out_is_main_block));
    end else begin
      want = pending_events.pop_front();
      results_checked++;
      ev_tally[want.ev]++;
      if (out_event_res !== want.ev)
        report_mismatch($sformatf("event %0d, expected %0d", out_event_res, want.ev));
      if (out_data_byte !== want.data)
        report_mismatch($sformatf("data_byte %02h, expected %02h", out_data_byte, want.data));
      if (out_block_length !== want.len)
        report_mismatch($sformatf("block_length %0d, expected %0d (event %0d)",
                                  out_block_length, want.len, want.ev));
      if (out_is_main_block !== want.main_blk)
        report_mismatch($sformatf("is_main_block %0b, expected %0b (event %0d)",
                                  out_is_main_block, want.main_blk, want.ev));
    end
  endtask

  // Both channels are sampled here, on pre-edge values. Results are checked
  // before the byte of the same edge is predicted; its event passes through the
  // result register and so can only come out later.
  always @(posedge clk) begin
    if (rst_n) begin
      if (out_valid && out_ready) check_event();
      if (in_valid && in_ready) predict_parser_events(in_byte_value, in_stream_done);
    end
  end

  // Watchdog: any transaction on either side resets the count.
  always @(posedge clk) begin
    if ((in_valid && in_ready) || (out_valid && out_ready)) begin
      quiet_cycles <= 0;
    end else if (quiet_cycles >= WATCHDOG_LIMIT) begin
      $display("TIMEOUT: no transaction for %0d cycles", WATCHDOG_LIMIT);
      $display("DONE: errors detected");
      $finish;
    end else begin
      quiet_cycles <= quiet_cycles + 1;
    end
  end

  // Result side backpressure: stall bursts of random length on out_ready.
  always @(posedge clk) begin
    if (!rst_n) begin
      out_ready  <= 1'b0;
      stall_left <= 0;
    end else if (stall_left != 0) begin
      out_ready  <= 1'b0;
      stall_left <= stall_left - 1;
    end else if (stall_pct != 0 && $urandom_range(0, 99) < stall_pct) begin
      out_ready  <= 1'b0;
      stall_left <= $urandom_range(0, 8);
    end else begin
      out_ready <= 1'b1;
    end
  end

  // ---------------------------------------------------------------------------
  // Driving
  // ---------------------------------------------------------------------------

  // Valid stays up from one transaction to the next unless a gap is taken,
  // so in_valid sees a single assignment per time step.
  task automatic send_item(input logic [7:0] b, input logic done);
    int gap;
    if (gap_pct != 0 && $urandom_range(0, 99) < gap_pct) begin
      gap = $urandom_range(1, 9);
      in_valid <= 1'b0;
      repeat (gap) @(posedge clk);
    end
    in_valid       <= 1'b1;
    in_byte_value  <= b;
    in_stream_done <= done;
    @(posedge clk);
    while (!in_ready) @(posedge clk);
    items_sent++;
  endtask

  // Drops valid and holds off until every predicted event has come back.
  task automatic wait_idle();
    in_valid <= 1'b0;
    @(posedge clk);
    while (pending_events.size() != 0) @(posedge clk);
    repeat (3) @(posedge clk);
  endtask

  task automatic write_reg(input logic [1:0] idx, input logic [15:0] val);
    cfg_we    <= 1'b1;
    cfg_index <= idx;
    cfg_wdata <= val;
    @(posedge clk);
    cfg_we <= 1'b0;
    @(posedge clk);
    case (idx)
      CFG_SIG_FIRST:  sig_first_q  = val[7:0];
      CFG_SIG_SECOND: sig_second_q = val[7:0];
      CFG_MAX_LEN:    max_len_q    = val;
      default: ;
    endcase
  endtask

  // ---------------------------------------------------------------------------
  // Stream building
  // ---------------------------------------------------------------------------

  function automatic void push_byte(input logic [7:0] b);
    stream_item_t s;
    s.done  = 1'b0;
    s.value = b;
    stream_plan.push_back(s);
  endfunction

  // The byte lane carries junk with the end marker; the parser must ignore it.
  function automatic void push_end();
    stream_item_t s;
    s.done  = 1'b1;
    s.value = 8'($urandom_range(0, 255));
    stream_plan.push_back(s);
  endfunction

  function automatic void push_length(input int len);
    logic [15:0] l16;
    l16 = 16'(len);
    push_byte(l16[7:0]);
    push_byte(l16[15:8]);
  endfunction

  // Length, random content, then the little-endian CRC (one bit off if bad).
  function automatic void push_block(input int len, input bit bad_crc);
    logic [31:0] crc;
    logic [7:0]  d;
    int          i;
    crc = CRC_INIT;
    push_length(len);
    for (i = 0; i < len; i++) begin
      d   = 8'($urandom_range(0, 255));
      crc = crc_step(crc, d);
      push_byte(d);
    end
    crc = ~crc;
    if (bad_crc) crc = crc ^ (32'h1 << $urandom_range(0, 31));
    for (i = 0; i < 4; i++) push_byte(crc[8*i +: 8]);
  endfunction

  // Mostly short legal lengths; also zero, the limit itself and just above it.
  function automatic int pick_length();
    int r;
    int over;
    r = $urandom_range(0, 99);
    if (r < 6) return 0;
    if (r < 12) begin
      if (max_len_q == 16'hFFFF) return 0;
      over = int'(max_len_q) + 1 + $urandom_range(0, 3);
      return (over > 65535) ? 65535 : over;
    end
    if (r < 20 && max_len_q <= 64) return int'(max_len_q);
    if (r < 85) return $urandom_range(1, 8);
    return $urandom_range(9, 40);
  endfunction

  function automatic int pick_idle_pct();
    case ($urandom_range(0, 3))
      0:       return 0;
      1:       return 5;
      2:       return 20;
      default: return 50;
    endcase
  endfunction

  // One header group: optional leading noise, signature (sometimes off by a
  // bit), a main block and up to three extended blocks, then the empty block.
  // Some groups are cut short by an end of stream, some stop at a bad length.
  function automatic void plan_group();
    int r;
    int nblk;
    int len;
    int k;
    int cut;
    bit closed;
    r = $urandom_range(0, 99);
    if (r < 8) begin
      repeat ($urandom_range(1, 6)) push_byte(8'($urandom_range(0, 255)));
    end
    r = $urandom_range(0, 99);
    push_byte((r < 5) ? (sig_first_q ^ (8'h01 << $urandom_range(0, 7))) : sig_first_q);
    push_byte((r >= 5 && r < 10) ?
              (sig_second_q ^ (8'h01 << $urandom_range(0, 7))) : sig_second_q);
    nblk   = $urandom_range(0, 3);
    closed = 1'b0;
    for (k = 0; k <= nblk && !closed; k++) begin
      len = pick_length();
      if (len == 0 || len > max_len_q) begin
        push_length(len);
        closed = 1'b1;
      end else begin
        push_block(len, $urandom_range(0, 99) < 5);
      end
    end
    if (!closed) push_length(0);
    if ($urandom_range(0, 99) < 7) begin
      cut = $urandom_range(1, stream_plan.size() - 1);
      while (stream_plan.size() > cut) void'(stream_plan.pop_back());
      push_end();
    end else if ($urandom_range(0, 99) < 15) begin
      push_end();
    end
  endfunction

  task automatic send_plan();
    foreach (stream_plan[i]) send_item(stream_plan[i].value, stream_plan[i].done);
    stream_plan.delete();
  endtask

  // Idling changes per group, so some groups run with no gaps at all.
  task automatic run_random_groups(input int until_items);
    while (items_sent < until_items) begin
      if (idling_on) begin
        gap_pct   = pick_idle_pct();
        stall_pct = pick_idle_pct();
      end else begin
        gap_pct   = 0;
        stall_pct = 0;
      end
      plan_group();
      send_plan();
    end
  endtask

  // ---------------------------------------------------------------------------
  // Tests
  // ---------------------------------------------------------------------------

  // Reset register values; one pass through each event kind.
  task automatic test_directed_cases();
    gap_pct   = 20;
    stall_pct = 20;
    // clean group: one-byte main block, empty extended block closes it
    push_byte(sig_first_q);
    push_byte(sig_second_q);
    push_block(1, 1'b0);
    push_length(0);
    // wrong second signature byte; hunt past a repeated first byte;
    // then a zero main length
    push_byte(sig_first_q);
    push_byte(8'h00);
    push_byte(sig_first_q);
    push_byte(sig_first_q);
    push_byte(sig_second_q);
    push_length(0);
    // end of stream while hunting, then at a group boundary: both silent
    push_end();
    push_end();
    // wrong first signature byte; after the hunt an oversize length
    push_byte(8'h00);
    push_byte(sig_second_q);
    push_byte(sig_first_q);
    push_byte(sig_second_q);
    push_length(16'hFFFF);
    // CRC mismatch
    push_byte(sig_first_q);
    push_byte(sig_second_q);
    push_block(1, 1'b1);
    // stream stops after one length byte: truncated, low byte reported
    push_byte(sig_first_q);
    push_byte(sig_second_q);
    push_byte(8'h01);
    push_end();
    send_plan();
    wait_idle();
  endtask

  // Signature bytes at 0x00/0xFF, length limit at one and at zero.
  task automatic test_register_extremes();
    write_reg(CFG_SIG_FIRST, 16'h0000);
    write_reg(CFG_SIG_SECOND, 16'h00FF);
    write_reg(CFG_MAX_LEN, 16'd1);
    run_random_groups(items_sent + 30);
    wait_idle();
    // limit zero: every nonzero length is rejected
    write_reg(CFG_SIG_FIRST, 16'h00FF);
    write_reg(CFG_SIG_SECOND, 16'h0000);
    write_reg(CFG_MAX_LEN, 16'd0);
    run_random_groups(items_sent + 20);
    wait_idle();
  endtask

  // Limit at its top: a block past 255 bytes, and the largest length
  // truncated a few bytes into its data.
  task automatic test_long_block();
    write_reg(CFG_SIG_FIRST, 16'($urandom_range(0, 255)));
    write_reg(CFG_SIG_SECOND, 16'($urandom_range(0, 255)));
    write_reg(CFG_MAX_LEN, 16'hFFFF);
    gap_pct   = 5;
    stall_pct = 5;
    push_byte(sig_first_q);
    push_byte(sig_second_q);
    push_block(256, 1'b0);
    push_block(2, 1'b0);
    push_length(0);
    push_byte(sig_first_q);
    push_byte(sig_second_q);
    push_length(16'hFFFF);
    repeat (3) push_byte(8'($urandom_range(0, 255)));
    push_end();
    send_plan();
    wait_idle();
  endtask

  // Bulk random stream. Upper write-data bits on the 8-bit registers are
  // junk and must be dropped. Halfway the sender holds off until drained.
  task automatic test_random_stream();
    int target;
    write_reg(CFG_SIG_FIRST, 16'($urandom_range(0, 65535)));
    write_reg(CFG_SIG_SECOND, 16'($urandom_range(0, 65535)));
    write_reg(CFG_MAX_LEN, 16'($urandom_range(12, 48)));
    target = items_sent + RANDOM_ITEMS;
    run_random_groups(items_sent + RANDOM_ITEMS / 2);
    wait_idle();
    run_random_groups(target);
    wait_idle();
  endtask

  // Reset values again, back to back with no idling on either side.
  task automatic test_full_rate();
    write_reg(CFG_SIG_FIRST, {8'h00, SIG_FIRST_RST});
    write_reg(CFG_SIG_SECOND, {8'h00, SIG_SECOND_RST});
    write_reg(CFG_MAX_LEN, MAX_LEN_RST);
    idling_on = 1'b0;
    run_random_groups(items_sent + 30);
  endtask

  initial begin
    repeat (8) @(posedge clk);
    rst_n <= 1'b1;
    repeat (2) @(posedge clk);
    test_directed_cases();
    test_register_extremes();
    test_long_block();
    test_random_stream();
    test_full_rate();
    wait_idle();
    repeat (10) @(posedge clk);
    $display("Covered %0d transactions, %0d events (%0d data, %0d ok, %0d group end)",
             items_sent, results_checked, ev_tally[EV_DATA], ev_tally[EV_OK],
             ev_tally[EV_END]);
    $display("Errors exercised: %0d bad signature, %0d crc, %0d truncated, %0d bad length",
             ev_tally[EV_BADSIG], ev_tally[EV_BADCRC], ev_tally[EV_TRUNC],
             ev_tally[EV_BADLEN]);
    if (error_count == 0) begin
      $display("DONE: 0 errors");
    end else begin
      $display("DONE: errors detected");
    end
    $finish;
  end

endmodule
